// File: rtl/core/lrb_pkg.sv
`timescale 1ns / 1ps

package lrb_pkg;

    localparam int NUM_REGS_DEF = 16;
    localparam int MAX_VARS_DEF = 64;

    localparam int KEY_W   = 16;
    localparam int LEVEL_W = 8;
    localparam int REG_W   = 6;
    localparam int STAMP_W = 32;
    localparam int OP_W    = 2;

    localparam logic [OP_W-1:0] OP_ACCESS = 2'd0;
    localparam logic [OP_W-1:0] OP_SPILL  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // one variable table entry; validity comes from the fill count
    typedef struct packed {
        logic               in_reg;
        logic [REG_W-1:0]   regn;
        logic [LEVEL_W-1:0] level;
        logic               is_global;
        logic [KEY_W-1:0]   key;
        logic [STAMP_W-1:0] stamp;
    } var_entry_t;

endpackage

// File: rtl/core/lru_register_binder_unit.sv
`timescale 1ns / 1ps

// Binds variables to a register file of NUM_REGS registers with LRU eviction.
// Raise start with opcode and operands while busy is low; exactly one result
// follows, held for a single cycle and flagged by done, which the receiver
// must take as it comes. Clear and unknown opcodes answer in the cycle after
// start. The variable table sits in one single-port-read memory that is
// scanned one entry per cycle: an access first scans the filled entries for
// its key and, once every register has been handed out, scans them again
// for the victim; a block spill scans them once.
// A table-full access answers with status 1 and changes nothing.
module lru_register_binder_unit
    import lrb_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEF,
    parameter int MAX_VARS = MAX_VARS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [OP_W-1:0]    opcode,
    input  logic [KEY_W-1:0]   var_key,
    input  logic               is_global,
    input  logic [LEVEL_W-1:0] level,
    output logic               done,
    output logic               status,
    output logic               load_needed,
    output logic [REG_W-1:0]   reg_res,
    output logic               out_is_global,
    output logic [KEY_W-1:0]   out_key
);

    localparam int IDX_W  = $clog2(MAX_VARS);
    localparam int CNT_W  = $clog2(MAX_VARS + 1);
    localparam int USED_W = $clog2(NUM_REGS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_ALLOC,
        S_BIND,
        S_VIC,
        S_FIN,
        S_SPILL
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [USED_W-1:0]  used_reg, used_next;
    logic [STAMP_W-1:0] clock_reg, clock_next;
    logic [IDX_W-1:0]   scan_reg, scan_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic               glob_reg, glob_next;
    logic [LEVEL_W-1:0] lvl_reg, lvl_next;
    var_entry_t         cur_reg, cur_next;
    var_entry_t         best_reg, best_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic               found_reg, found_next;

    logic               done_reg, done_next;
    logic               status_reg, status_next;
    logic               load_reg, load_next;
    logic [REG_W-1:0]   regres_reg, regres_next;
    logic               outglob_reg, outglob_next;
    logic [KEY_W-1:0]   outkey_reg, outkey_next;

    // entry memory
    var_entry_t         mem [MAX_VARS];
    var_entry_t         rd_data_reg;
    logic [IDX_W-1:0]   mem_raddr;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    var_entry_t         mem_wdata;

    logic               last_scan;
    logic               take;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    assign last_scan = ((CNT_W'(scan_reg) + 1'b1) == cnt_reg);
    assign take      = rd_data_reg.in_reg && (scan_reg != idx_reg) &&
                       (!found_reg || (rd_data_reg.stamp < best_reg.stamp));

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        used_next     = used_reg;
        clock_next    = clock_reg;
        scan_next     = scan_reg;
        idx_next      = idx_reg;
        key_next      = key_reg;
        glob_next     = glob_reg;
        lvl_next      = lvl_reg;
        cur_next      = cur_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        found_next    = found_reg;
        done_next     = 1'b0;
        status_next   = STATUS_OK;
        load_next     = 1'b0;
        regres_next   = '0;
        outglob_next  = 1'b0;
        outkey_next   = '0;
        mem_raddr     = scan_reg + 1'b1;
        mem_we        = 1'b0;
        mem_waddr     = scan_reg;
        mem_wdata     = rd_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                mem_raddr = '0;
                if (start)
                begin
                    key_next  = var_key;
                    glob_next = is_global;
                    lvl_next  = level;
                    scan_next = '0;
                    case (opcode)
                        OP_ACCESS:
                        begin
                            state_next = (cnt_reg == '0) ? S_ALLOC : S_LOOK;
                        end
                        OP_SPILL:
                        begin
                            if (cnt_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SPILL;
                            end
                        end
                        OP_CLEAR:
                        begin
                            cnt_next   = '0;
                            used_next  = '0;
                            clock_next = '0;
                            done_next  = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_LOOK:
            begin
                if ((rd_data_reg.key == key_reg) && (rd_data_reg.is_global == glob_reg))
                begin
                    idx_next       = scan_reg;
                    cur_next       = rd_data_reg;
                    cur_next.stamp = clock_reg;
                    clock_next     = clock_reg + 1'b1;
                    if (rd_data_reg.in_reg)
                    begin
                        mem_we          = 1'b1;
                        mem_wdata.stamp = clock_reg;
                        done_next       = 1'b1;
                        regres_next     = rd_data_reg.regn;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_BIND;
                    end
                end
                else if (last_scan)
                begin
                    state_next = S_ALLOC;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            S_ALLOC:
            begin
                if (cnt_reg == CNT_W'(MAX_VARS))
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_FULL;
                    state_next  = S_IDLE;
                end
                else
                begin
                    idx_next           = cnt_reg[IDX_W-1:0];
                    cnt_next           = cnt_reg + 1'b1;
                    cur_next           = '0;
                    cur_next.is_global = glob_reg;
                    cur_next.key       = key_reg;
                    cur_next.stamp     = clock_reg;
                    clock_next         = clock_reg + 1'b1;
                    state_next         = S_BIND;
                end
            end

            S_BIND:
            begin
                mem_raddr = '0;
                if (used_reg < USED_W'(NUM_REGS))
                begin
                    cur_next.regn = REG_W'(used_reg);
                    used_next     = used_reg + 1'b1;
                    state_next    = S_FIN;
                end
                else
                begin
                    scan_next  = '0;
                    found_next = 1'b0;
                    state_next = S_VIC;
                end
            end

            S_VIC:
            begin
                if (take)
                begin
                    best_next     = rd_data_reg;
                    best_idx_next = scan_reg;
                    found_next    = 1'b1;
                end
                if (last_scan)
                begin
                    // evict the oldest in-register entry, or fall back to register 0
                    if (take)
                    begin
                        mem_we           = 1'b1;
                        mem_waddr        = scan_reg;
                        mem_wdata        = rd_data_reg;
                        mem_wdata.in_reg = 1'b0;
                        cur_next.regn    = rd_data_reg.regn;
                    end
                    else if (found_reg)
                    begin
                        mem_we           = 1'b1;
                        mem_waddr        = best_idx_reg;
                        mem_wdata        = best_reg;
                        mem_wdata.in_reg = 1'b0;
                        cur_next.regn    = best_reg.regn;
                    end
                    else
                    begin
                        cur_next.regn = '0;
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            S_FIN:
            begin
                mem_we           = 1'b1;
                mem_waddr        = idx_reg;
                mem_wdata        = cur_reg;
                mem_wdata.in_reg = 1'b1;
                mem_wdata.level  = lvl_reg;
                done_next        = 1'b1;
                load_next        = 1'b1;
                regres_next      = cur_reg.regn;
                outglob_next     = glob_reg;
                outkey_next      = key_reg;
                state_next       = S_IDLE;
            end

            S_SPILL:
            begin
                if (rd_data_reg.in_reg && (rd_data_reg.level >= lvl_reg))
                begin
                    mem_we           = 1'b1;
                    mem_wdata.in_reg = 1'b0;
                end
                if (last_scan)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            used_reg    <= '0;
            clock_reg   <= '0;
            found_reg   <= 1'b0;
            done_reg    <= 1'b0;
            status_reg  <= STATUS_OK;
            load_reg    <= 1'b0;
            regres_reg  <= '0;
            outglob_reg <= 1'b0;
            outkey_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            used_reg    <= used_next;
            clock_reg   <= clock_next;
            found_reg   <= found_next;
            done_reg    <= done_next;
            status_reg  <= status_next;
            load_reg    <= load_next;
            regres_reg  <= regres_next;
            outglob_reg <= outglob_next;
            outkey_reg  <= outkey_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg     <= scan_next;
        idx_reg      <= idx_next;
        key_reg      <= key_next;
        glob_reg     <= glob_next;
        lvl_reg      <= lvl_next;
        cur_reg      <= cur_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign load_needed   = load_reg;
    assign reg_res       = regres_reg;
    assign out_is_global = outglob_reg;
    assign out_key       = outkey_reg;

endmodule

// File: rtl/core/lrb_checker.sv
`timescale 1ns / 1ps

module lrb_checker
    import lrb_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEF
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic               status,
    input logic               load_needed,
    input logic [REG_W-1:0]   reg_res,
    input logic               out_is_global,
    input logic [KEY_W-1:0]   out_key
);

    // an accepted transaction either answers at once or keeps the unit busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted transaction neither answered nor in progress");

    a_busy_ends_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_full_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STATUS_FULL)) |-> (!load_needed && (reg_res == '0)))
        else $error("table-full result carries a binding");

    a_no_load_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !load_needed) |-> (!out_is_global && (out_key == '0)))
        else $error("load fields set without a load");

    a_reg_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (int'(reg_res) < NUM_REGS))
        else $error("register index out of range");

endmodule

bind lru_register_binder_unit lrb_checker #(.NUM_REGS(NUM_REGS)) u_lrb_checker (.*);
